// File: design/aau_pkg.sv
// aau_pkg: shared widths, vector types and the arctangent table for the aspect angle unit
// no dependencies; imported by every module of the block
package aau_pkg;

  localparam int D_W       = 33;   // position difference after scaling
  localparam int U_W       = 16;   // Q2.14 unit vector component
  localparam int G_W       = 17;   // reversed forward component
  localparam int DU_W      = D_W + U_W;
  localparam int P_W       = 38;   // projection length
  localparam int PU_W      = P_W + U_W;
  localparam int V_W       = 38;   // projected vector component
  localparam int PR_W      = V_W + G_W;
  localparam int CT_W      = 58;   // cross and dot results
  localparam int LEN_W     = 6;    // bit length of a CT_W magnitude
  localparam int N_W       = 31;   // normalised component
  localparam int SQ_W      = 64;   // sum of squares
  localparam int RT_W      = 32;   // square root
  localparam int REM_W     = 36;   // square root remainder
  localparam int CX_W      = 34;   // cordic x and y
  localparam int Z_W       = 30;   // cordic angle accumulator
  localparam int ACC_FRAC  = 20;
  localparam int TABLE_LEN = 24;
  localparam int NORM_BITS = 30;
  localparam int OUT_W     = 15;

  typedef logic signed [U_W-1:0]  ucomp_t;
  typedef logic signed [G_W-1:0]  gcomp_t;
  typedef logic signed [V_W-1:0]  vcomp_t;
  typedef logic signed [N_W-1:0]  ncomp_t;
  typedef logic [SQ_W-1:0]        sq_t;
  typedef logic [RT_W-1:0]        root_t;

  // atan(2^-i) in degrees, 2^-20 degree units
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:  a = 30'sd47185920;
      5'd1:  a = 30'sd27855475;
      5'd2:  a = 30'sd14718068;
      5'd3:  a = 30'sd7471121;
      5'd4:  a = 30'sd3750058;
      5'd5:  a = 30'sd1876857;
      5'd6:  a = 30'sd938658;
      5'd7:  a = 30'sd469357;
      5'd8:  a = 30'sd234682;
      5'd9:  a = 30'sd117342;
      5'd10: a = 30'sd58671;
      5'd11: a = 30'sd29335;
      5'd12: a = 30'sd14668;
      5'd13: a = 30'sd7334;
      5'd14: a = 30'sd3667;
      5'd15: a = 30'sd1833;
      5'd16: a = 30'sd917;
      5'd17: a = 30'sd458;
      5'd18: a = 30'sd229;
      5'd19: a = 30'sd115;
      5'd20: a = 30'sd57;
      5'd21: a = 30'sd29;
      5'd22: a = 30'sd14;
      5'd23: a = 30'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: design/aspect_angle_unit_top.sv
// aspect_angle_unit_top: top level of the aspect angle unit
// depends on aau_pkg, aau_proj, aau_norm, aau_isqrt and aau_cordic
//
// usage
// - input channel in_valid/in_ready carries one geometry beat: own and target
//   positions, the target's forward and up vectors (Q2.14)
// - output channel out_valid/out_ready carries one beat per input beat: the
//   aspect angle in 2^-ANGLE_FRAC_BITS degree, 0 dead six, 180 degrees head-on
// - throughput is one beat per cycle while out_ready keeps results moving;
//   every stage is a register stage
// - a beat runs through projection, products and normalising, the square
//   root with one root bit per stage, pre-rotation, the cordic stages, and
//   round and clamp
// - the round and clamp register is the output register; while a finished
//   result waits unclaimed no new beat is taken, even with bubbles inside
// - when the receiver stalls with a result waiting, the whole pipeline holds;
//   nothing is lost or repeated, and in_ready drops until out_ready returns
// - reset (rst_n low, synchronous) clears every valid bit; payload registers
//   are not reset
// - a zero projected vector gives an angle of 0
module aspect_angle_unit_top #(
  parameter int POS_WIDTH       = 32,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_WIDTH-1:0] in_own_x,
  input  logic signed [POS_WIDTH-1:0] in_own_y,
  input  logic signed [POS_WIDTH-1:0] in_own_z,
  input  logic signed [POS_WIDTH-1:0] in_tgt_x,
  input  logic signed [POS_WIDTH-1:0] in_tgt_y,
  input  logic signed [POS_WIDTH-1:0] in_tgt_z,
  input  logic signed [15:0]          in_fwd_x,
  input  logic signed [15:0]          in_fwd_y,
  input  logic signed [15:0]          in_fwd_z,
  input  logic signed [15:0]          in_up_x,
  input  logic signed [15:0]          in_up_y,
  input  logic signed [15:0]          in_up_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [14:0]                 out_aspect_deg
);
  import aau_pkg::*;

  // global advance: the pipeline moves unless a result sits unclaimed
  logic en;

  logic signed [POS_WIDTH-1:0] own [3];
  logic signed [POS_WIDTH-1:0] tgt [3];
  ucomp_t fwd [3];
  ucomp_t up  [3];

  logic   proj_v, norm_v, sqrt_v;
  vcomp_t v   [3];
  gcomp_t g   [3];
  sq_t    sq;
  ncomp_t t_n, t_s;
  root_t  root;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  assign own = '{in_own_x, in_own_y, in_own_z};
  assign tgt = '{in_tgt_x, in_tgt_y, in_tgt_z};
  assign fwd = '{in_fwd_x, in_fwd_y, in_fwd_z};
  assign up  = '{in_up_x, in_up_y, in_up_z};

  // d = own - tgt, projected onto the target's horizontal plane
  aau_proj #(
    .POS_WIDTH(POS_WIDTH)
  ) u_proj (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_valid && in_ready),
    .own_i(own), .tgt_i(tgt), .fwd_i(fwd), .up_i(up),
    .valid_o(proj_v), .v_o(v), .g_o(g)
  );

  // cross and dot with the reversed forward vector, scaled below 2^30
  aau_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(proj_v), .v_i(v), .g_i(g),
    .valid_o(norm_v), .sq_o(sq), .t_o(t_n)
  );

  // |cross| as a floor square root
  aau_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(norm_v), .sq_i(sq), .t_i(t_n),
    .valid_o(sqrt_v), .root_o(root), .t_o(t_s)
  );

  // atan2(|cross|, dot) in degrees, holds the output register
  aau_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(sqrt_v), .root_i(root), .t_i(t_s),
    .valid_o(out_valid), .angle_o(out_aspect_deg)
  );

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_aspect_deg))
    else $error("stalled result changed");

  // result never beyond head-on when the format holds it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ANGLE_FRAC_BITS > 7) ||
                  (out_aspect_deg <= 15'(180 << ANGLE_FRAC_BITS)))
    else $error("aspect angle above head-on");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is held off only while a result sits unclaimed
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled result");

endmodule

// File: design/aau_proj.sv
// aau_proj: difference of positions and projection into the target's horizontal plane
// depends on aau_pkg
module aau_proj #(
  parameter int POS_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic signed [POS_WIDTH-1:0] own_i [3],
  input  logic signed [POS_WIDTH-1:0] tgt_i [3],
  input  aau_pkg::ucomp_t             fwd_i [3],
  input  aau_pkg::ucomp_t             up_i  [3],
  output logic                        valid_o,
  output aau_pkg::vcomp_t             v_o   [3],
  output aau_pkg::gcomp_t             g_o   [3]
);
  import aau_pkg::*;

  localparam int SH = (POS_WIDTH > 32) ? POS_WIDTH - 32 : 0;

  logic [4:0] vld_r;
  logic signed [D_W-1:0]  d1_r [3], d2_r [3], d3_r [3], d4_r [3];
  ucomp_t                 u1_r [3], u2_r [3], u3_r [3];
  gcomp_t                 g1_r [3], g2_r [3], g3_r [3], g4_r [3], g5_r [3];
  logic signed [DU_W-1:0] du_r [3];
  logic signed [P_W-1:0]  p_r;
  logic signed [PU_W-1:0] pu_r [3];
  vcomp_t                 v_r  [3];

  logic signed [POS_WIDTH:0] diff [3];
  logic signed [DU_W+1:0]    psum;
  logic signed [P_W-1:0]     p_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (POS_WIDTH + 1)'(own_i[k]) - (POS_WIDTH + 1)'(tgt_i[k]);
    end
    psum = (DU_W + 2)'(du_r[0]) + (DU_W + 2)'(du_r[1]) + (DU_W + 2)'(du_r[2])
         + (DU_W + 2)'(1 << 13);
    p_nxt = P_W'(psum >>> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= D_W'(diff[k] >>> SH);
        u1_r[k] <= up_i[k];
        g1_r[k] <= -G_W'(fwd_i[k]);
        du_r[k] <= d1_r[k] * u1_r[k];
        d2_r[k] <= d1_r[k];
        u2_r[k] <= u1_r[k];
        g2_r[k] <= g1_r[k];
        d3_r[k] <= d2_r[k];
        u3_r[k] <= u2_r[k];
        g3_r[k] <= g2_r[k];
        pu_r[k] <= p_r * u3_r[k];
        d4_r[k] <= d3_r[k];
        g4_r[k] <= g3_r[k];
        // remove the rounded component along up
        v_r[k]  <= V_W'(d4_r[k]) - V_W'((pu_r[k] + PU_W'(1 << 13)) >>> 14);
        g5_r[k] <= g4_r[k];
      end
      p_r <= p_nxt;
    end
  end

  assign valid_o = vld_r[4];
  assign v_o = v_r;
  assign g_o = g5_r;

endmodule

// File: design/aau_norm.sv
// aau_norm: cross and dot product, common normalising shift and sum of squares
// depends on aau_pkg
module aau_norm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  aau_pkg::vcomp_t        v_i [3],
  input  aau_pkg::gcomp_t        g_i [3],
  output logic                   valid_o,
  output aau_pkg::sq_t           sq_o,
  output aau_pkg::ncomp_t        t_o
);
  import aau_pkg::*;

  logic [6:0] vld_r;
  logic signed [PR_W-1:0]  pr_r [9];
  logic signed [CT_W-1:0]  c_r [3], c3_r [3], c4_r [3];
  logic signed [CT_W-1:0]  t_r, t3_r, t4_r;
  logic [CT_W-1:0]         m_r;
  logic [LEN_W-1:0]        s_r;
  ncomp_t                  cs_r [3];
  ncomp_t                  ts_r, ts6_r, ts7_r;
  logic signed [2*N_W-1:0] sqp_r [3];
  sq_t                     sq_r;

  logic [CT_W-1:0]  m_nxt;
  logic [LEN_W-1:0] len;

  function automatic logic [CT_W-1:0] mag(input logic signed [CT_W-1:0] a);
    return a[CT_W-1] ? CT_W'(-a) : CT_W'(a);
  endfunction

  always_comb begin
    m_nxt = mag(c_r[0]) | mag(c_r[1]) | mag(c_r[2]) | mag(t_r);
    len = '0;
    for (int i = 0; i < CT_W; i++) begin
      if (m_r[i]) len = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= v_i[1] * g_i[2];
      pr_r[1] <= v_i[2] * g_i[1];
      pr_r[2] <= v_i[2] * g_i[0];
      pr_r[3] <= v_i[0] * g_i[2];
      pr_r[4] <= v_i[0] * g_i[1];
      pr_r[5] <= v_i[1] * g_i[0];
      pr_r[6] <= v_i[0] * g_i[0];
      pr_r[7] <= v_i[1] * g_i[1];
      pr_r[8] <= v_i[2] * g_i[2];
      c_r[0] <= CT_W'(pr_r[0]) - CT_W'(pr_r[1]);
      c_r[1] <= CT_W'(pr_r[2]) - CT_W'(pr_r[3]);
      c_r[2] <= CT_W'(pr_r[4]) - CT_W'(pr_r[5]);
      t_r    <= CT_W'(pr_r[6]) + CT_W'(pr_r[7]) + CT_W'(pr_r[8]);
      m_r  <= m_nxt;
      c3_r <= c_r;
      t3_r <= t_r;
      // bit length of the largest magnitude sets the shift
      s_r  <= (len > LEN_W'(NORM_BITS)) ? len - LEN_W'(NORM_BITS) : '0;
      c4_r <= c3_r;
      t4_r <= t3_r;
      for (int k = 0; k < 3; k++) begin
        cs_r[k]  <= N_W'(c4_r[k] >>> s_r);
        sqp_r[k] <= cs_r[k] * cs_r[k];
      end
      ts_r  <= N_W'(t4_r >>> s_r);
      ts6_r <= ts_r;
      sq_r  <= SQ_W'(sqp_r[0]) + SQ_W'(sqp_r[1]) + SQ_W'(sqp_r[2]);
      ts7_r <= ts6_r;
    end
  end

  assign valid_o = vld_r[6];
  assign sq_o = sq_r;
  assign t_o = ts7_r;

endmodule

// File: design/aau_isqrt.sv
// aau_isqrt: pipelined integer square root, one root bit per stage
// depends on aau_pkg
module aau_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  aau_pkg::sq_t    sq_i,
  input  aau_pkg::ncomp_t t_i,
  output logic            valid_o,
  output aau_pkg::root_t  root_o,
  output aau_pkg::ncomp_t t_o
);
  import aau_pkg::*;

  logic             vld_r  [RT_W];
  sq_t              n_r    [RT_W];
  logic [REM_W-1:0] rem_r  [RT_W];
  root_t            root_r [RT_W];
  ncomp_t           t_r    [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic             vld_in;
    sq_t              n_in;
    logic [REM_W-1:0] rem_in, rem2, trial;
    root_t            root_in;
    ncomp_t           t_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign n_in    = sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign t_in    = t_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign t_in    = t_r[k-1];
    end

    assign rem2  = {rem_in[REM_W-3:0], n_in[SQ_W-1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= {n_in[SQ_W-3:0], 2'b00};
        t_r[k] <= t_in;
        if (rem2 >= trial) begin
          rem_r[k]  <= rem2 - trial;
          root_r[k] <= {root_in[RT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem2;
          root_r[k] <= {root_in[RT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_r[RT_W-1];
  assign root_o = root_r[RT_W-1];
  assign t_o = t_r[RT_W-1];

endmodule

// File: design/aau_cordic.sv
// aau_cordic: vectoring cordic on (dot, |cross|), rounding and clamp to the angle format
// depends on aau_pkg
module aau_cordic #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       valid_i,
  input  aau_pkg::root_t             root_i,
  input  aau_pkg::ncomp_t            t_i,
  output logic                       valid_o,
  output logic [aau_pkg::OUT_W-1:0]  angle_o
);
  import aau_pkg::*;

  localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int RSH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF = Z_W'(1 << (RSH - 1));
  localparam logic signed [Z_W-1:0] LIM  = Z_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [Z_W-1:0] QTR  = Z_W'(90 << ACC_FRAC);

  logic                   pv_r, pzero_r;
  logic signed [CX_W-1:0] px_r, py_r;
  logic signed [Z_W-1:0]  pz_r;

  logic                   vld_r  [NST];
  logic                   zero_r [NST];
  logic signed [CX_W-1:0] x_r    [NST];
  logic signed [CX_W-1:0] y_r    [NST];
  logic signed [Z_W-1:0]  z_r    [NST];

  logic                   out_v_r;
  logic [OUT_W-1:0]       out_r;
  logic signed [Z_W-1:0]  rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= valid_i;
    end
  end

  // left half plane: turn by -90 degrees first
  always_ff @(posedge clk) begin
    if (en) begin
      pzero_r <= (t_i == '0) && (root_i == '0);
      if (t_i[N_W-1]) begin
        px_r <= CX_W'({1'b0, root_i});
        py_r <= -CX_W'(t_i);
        pz_r <= QTR;
      end else begin
        px_r <= CX_W'(t_i);
        py_r <= CX_W'({1'b0, root_i});
        pz_r <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic                   vld_in, zero_in;
    logic signed [CX_W-1:0] x_in, y_in;
    logic signed [Z_W-1:0]  z_in;

    if (i == 0) begin : g_first
      assign vld_in  = pv_r;
      assign zero_in = pzero_r;
      assign x_in    = px_r;
      assign y_in    = py_r;
      assign z_in    = pz_r;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign zero_in = zero_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i] <= zero_in;
        if (!y_in[CX_W-1]) begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + atan_lut(5'(i));
        end else begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - atan_lut(5'(i));
        end
      end
    end
  end

  assign rnd = (z_r[NST-1] + HALF) >>> RSH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[NST-1] || rnd[Z_W-1]) begin
        out_r <= '0;
      end else if (rnd > LIM) begin
        out_r <= OUT_W'(LIM);
      end else begin
        out_r <= OUT_W'(rnd);
      end
    end
  end

  assign valid_o = out_v_r;
  assign angle_o = out_r;

endmodule
